[sv/sit_pkg.sv]
`default_nettype none

package sit_pkg;

	// Default sizes of the entry table, the parameter pool and one parameter list.
	localparam int unsigned DEF_ENTRIES    = 4096;
	localparam int unsigned DEF_POOL_WORDS = 4096;
	localparam int unsigned DEF_MAX_PARAMS = 16;

	// Field widths fixed by the interface.
	localparam int unsigned OPCODE_W = 4;
	localparam int unsigned KEY_W    = 32;
	localparam int unsigned KIND_W   = 4;
	localparam int unsigned INDEX_W  = 12;
	localparam int unsigned STATUS_W = 2;

	// Width used to check the next index against the table limits.
	localparam int unsigned NEXT_W      = 17;
	localparam logic [NEXT_W-1:0] INDEX_LIMIT = 17'h0FF00;

	// Reset value of the first free index register.
	localparam logic [INDEX_W-1:0] FIRST_FREE_RESET = 12'd2;

	// Opcodes.
	localparam logic [OPCODE_W-1:0] OP_VEC    = 4'd0;
	localparam logic [OPCODE_W-1:0] OP_ARR    = 4'd1;
	localparam logic [OPCODE_W-1:0] OP_MAP    = 4'd2;
	localparam logic [OPCODE_W-1:0] OP_BUF    = 4'd3;
	localparam logic [OPCODE_W-1:0] OP_PTR    = 4'd4;
	localparam logic [OPCODE_W-1:0] OP_FUTURE = 4'd5;
	localparam logic [OPCODE_W-1:0] OP_BOX    = 4'd6;
	localparam logic [OPCODE_W-1:0] OP_PROC   = 4'd7;
	localparam logic [OPCODE_W-1:0] OP_QUERY  = 4'd8;

	// Stored kind codes.
	localparam logic [KIND_W-1:0] KIND_NONE   = 4'd0;
	localparam logic [KIND_W-1:0] KIND_VEC    = 4'd3;
	localparam logic [KIND_W-1:0] KIND_MAP    = 4'd4;
	localparam logic [KIND_W-1:0] KIND_BUF    = 4'd5;
	localparam logic [KIND_W-1:0] KIND_PTR    = 4'd6;
	localparam logic [KIND_W-1:0] KIND_FUTURE = 4'd7;
	localparam logic [KIND_W-1:0] KIND_BOX    = 4'd8;
	localparam logic [KIND_W-1:0] KIND_ARR    = 4'd9;
	localparam logic [KIND_W-1:0] KIND_PROC   = 4'd10;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STAT_FOUND    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_ADDED    = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_TOO_LONG = 2'd3;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_QREAD,
		S_SCAN,
		S_CHECK,
		S_PREAD,
		S_PCMP,
		S_INSERT,
		S_COPY,
		S_RESP
	} state_t;

	// Kind code stored for each shape opcode.
	function automatic logic [KIND_W-1:0] op_to_kind(input logic [OPCODE_W-1:0] op);
		logic [KIND_W-1:0] k;
		begin
			unique case (op)
				OP_VEC:    k = KIND_VEC;
				OP_ARR:    k = KIND_ARR;
				OP_MAP:    k = KIND_MAP;
				OP_BUF:    k = KIND_BUF;
				OP_PTR:    k = KIND_PTR;
				OP_FUTURE: k = KIND_FUTURE;
				OP_BOX:    k = KIND_BOX;
				OP_PROC:   k = KIND_PROC;
				default:   k = KIND_NONE;
			endcase
			return k;
		end
	endfunction

endpackage

`default_nettype wire

[sv/sit_ram.sv]
`default_nettype none

module sit_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 4096,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[sv/shape_intern_table.sv]
// Flow: a query reads its entry in S_QREAD and answers from S_RESP; a lookup scans the stored
// entries (S_SCAN, S_CHECK), compares parameters (S_PREAD, S_PCMP) and inserts (S_INSERT, S_COPY).
// Throughput: one item at a time, in_stall holds the input outside S_IDLE; proc items without
// the last flag are taken without leaving S_IDLE. The scan reads and checks each entry in turn.
// Reset: arst_n clears the entry count, pool fill, pending parameter list and the output valid flag;
// first_free_index returns to 2. The memories are not cleared.
`default_nettype none

module shape_intern_table #(
	parameter int unsigned ENTRIES    = sit_pkg::DEF_ENTRIES,
	parameter int unsigned POOL_WORDS = sit_pkg::DEF_POOL_WORDS,
	parameter int unsigned MAX_PARAMS = sit_pkg::DEF_MAX_PARAMS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [sit_pkg::INDEX_W-1:0]   cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [sit_pkg::OPCODE_W-1:0]  opcode,
	input  wire logic [sit_pkg::KEY_W-1:0]     key_a,
	input  wire logic [sit_pkg::KEY_W-1:0]     key_b,
	input  wire logic [sit_pkg::KEY_W-1:0]     param_value,
	input  wire logic                          param_valid,
	input  wire logic                          last,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [sit_pkg::STATUS_W-1:0]  status,
	output logic      [sit_pkg::INDEX_W-1:0]   index,
	output logic      [sit_pkg::KIND_W-1:0]    kind
);

	import sit_pkg::*;

	localparam int unsigned EW    = $clog2(ENTRIES);
	localparam int unsigned CNTW  = $clog2(ENTRIES + 1);
	localparam int unsigned PW    = (POOL_WORDS > 1) ? $clog2(POOL_WORDS) : 1;
	localparam int unsigned FILLW = $clog2(POOL_WORDS + 1);
	localparam int unsigned LENW  = $clog2(MAX_PARAMS + 1);
	localparam int unsigned PIW   = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
	localparam int unsigned SUMW  = ((FILLW > LENW) ? FILLW : LENW) + 1;
	localparam int unsigned ENT_W = KIND_W + 2 * KEY_W + LENW + FILLW;

	// Bit positions inside one packed entry word.
	localparam int unsigned OFF_LO  = 0;
	localparam int unsigned LEN_LO  = FILLW;
	localparam int unsigned KEYB_LO = LEN_LO + LENW;
	localparam int unsigned KEYA_LO = KEYB_LO + KEY_W;
	localparam int unsigned KIND_LO = KEYA_LO + KEY_W;

	state_t state_q, state_d;

	logic [INDEX_W-1:0]  first_free_q;
	logic [CNTW-1:0]     used_q;
	logic [FILLW-1:0]    fill_q;
	logic [LENW-1:0]     req_len_q;
	logic                req_over_q;
	logic [KEY_W-1:0]    req_params_q [MAX_PARAMS];

	logic [KIND_W-1:0]   kind_q;
	logic [KEY_W-1:0]    key_a_q;
	logic [KEY_W-1:0]    key_b_q;
	logic [LENW-1:0]     cur_len_q;
	logic [CNTW-1:0]     scan_q;
	logic [LENW-1:0]     k_q;
	logic [FILLW-1:0]    off_q;
	logic [KEY_W-1:0]    param_q;
	logic                qhit_q;

	logic [STATUS_W-1:0] res_status_q;
	logic [INDEX_W-1:0]  res_index_q;
	logic [KIND_W-1:0]   res_kind_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [INDEX_W-1:0]  out_index_q;
	logic [KIND_W-1:0]   out_kind_q;

	logic                accept;
	logic                is_proc;
	logic                is_query;
	logic                is_known;
	logic                store_param;
	logic [LENW-1:0]     len_next;
	logic                over_next;
	logic [KEY_W-1:0]    qoff;
	logic                qhit;
	logic                ent_match;
	logic                scan_done;
	logic [NEXT_W-1:0]   next_idx;
	logic [SUMW-1:0]     pool_need;
	logic                full;
	logic                out_free;
	logic [KEY_W-1:0]    req_param_rd;

	logic                ent_we;
	logic [EW-1:0]       ent_waddr;
	logic [ENT_W-1:0]    ent_wdata;
	logic [EW-1:0]       ent_raddr;
	logic [ENT_W-1:0]    ent_rdata;
	logic                pool_we;
	logic [PW-1:0]       pool_waddr;
	logic [PW-1:0]       pool_raddr;
	logic [KEY_W-1:0]    pool_rdata;

	// Entry memory: kind, both keys, parameter count and pool offset.
	sit_ram #(
		.WIDTH(ENT_W),
		.DEPTH(ENTRIES)
	) u_entry_ram (
		.clk  (clk),
		.we   (ent_we),
		.waddr(ent_waddr),
		.wdata(ent_wdata),
		.raddr(ent_raddr),
		.rdata(ent_rdata)
	);

	// Parameter pool memory.
	sit_ram #(
		.WIDTH(KEY_W),
		.DEPTH(POOL_WORDS)
	) u_pool_ram (
		.clk  (clk),
		.we   (pool_we),
		.waddr(pool_waddr),
		.wdata(req_param_rd),
		.raddr(pool_raddr),
		.rdata(pool_rdata)
	);

	// Input decode and the running parameter list.
	assign in_stall    = (state_q != S_IDLE);
	assign accept      = in_valid && !in_stall;
	assign is_proc     = (opcode == OP_PROC);
	assign is_query    = (opcode == OP_QUERY);
	assign is_known    = (opcode <= OP_QUERY);
	assign store_param = param_valid && (req_len_q < LENW'(MAX_PARAMS));
	assign len_next    = req_len_q + LENW'(store_param);
	assign over_next   = req_over_q || (param_valid && (req_len_q == LENW'(MAX_PARAMS)));

	// A query hits when the index falls inside the appended entries.
	assign qoff = key_a - KEY_W'(first_free_q);
	assign qhit = (key_a >= KEY_W'(first_free_q)) && (qoff < KEY_W'(used_q));

	// Scan comparison against the entry read in the previous cycle.
	assign ent_match = (ent_rdata[KIND_LO +: KIND_W] == kind_q)
		&& (ent_rdata[KEYA_LO +: KEY_W] == key_a_q)
		&& (ent_rdata[KEYB_LO +: KEY_W] == key_b_q)
		&& (ent_rdata[LEN_LO +: LENW] == cur_len_q);
	assign scan_done = (scan_q >= used_q);

	// Room checks for an append.
	assign next_idx  = NEXT_W'(first_free_q) + NEXT_W'(used_q);
	assign pool_need = SUMW'(fill_q) + SUMW'(cur_len_q);
	assign full = (used_q >= CNTW'(ENTRIES)) || (next_idx >= NEXT_W'(ENTRIES))
		|| (next_idx >= INDEX_LIMIT) || (pool_need > SUMW'(POOL_WORDS));

	assign out_free     = !out_valid_q || !out_stall;
	assign req_param_rd = req_params_q[k_q[PIW-1:0]];

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && is_known) begin
					if (is_query) begin
						state_d = S_QREAD;
					end else if (is_proc && !last) begin
						state_d = S_IDLE;
					end else if (is_proc && over_next) begin
						state_d = S_RESP;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_QREAD: state_d = S_RESP;
			S_SCAN:  state_d = scan_done ? S_INSERT : S_CHECK;
			S_CHECK: state_d = ent_match ? S_PREAD : S_SCAN;
			S_PREAD: state_d = (k_q == cur_len_q) ? S_RESP : S_PCMP;
			S_PCMP:  state_d = (pool_rdata == param_q) ? S_PREAD : S_SCAN;
			S_INSERT: state_d = full ? S_RESP : S_COPY;
			S_COPY:  state_d = (k_q == cur_len_q) ? S_RESP : S_COPY;
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Memory controls.
	always_comb begin
		ent_we     = (state_q == S_INSERT) && !full;
		ent_waddr  = used_q[EW-1:0];
		ent_wdata  = {kind_q, key_a_q, key_b_q, cur_len_q, fill_q};
		ent_raddr  = (state_q == S_IDLE) ? qoff[EW-1:0] : scan_q[EW-1:0];
		pool_we    = (state_q == S_COPY) && (k_q != cur_len_q);
		pool_waddr = PW'(fill_q + FILLW'(k_q));
		pool_raddr = PW'(off_q + FILLW'(k_q));
	end

	// Sequencer state and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			first_free_q <= FIRST_FREE_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				first_free_q <= cfg_wdata;
			end
		end
	end

	// Table counts and the pending parameter list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			fill_q     <= '0;
			req_len_q  <= '0;
			req_over_q <= 1'b0;
		end else begin
			if (accept && is_proc) begin
				req_len_q  <= last ? '0 : len_next;
				req_over_q <= last ? 1'b0 : over_next;
			end
			if ((state_q == S_COPY) && (k_q == cur_len_q)) begin
				used_q <= used_q + CNTW'(1);
				fill_q <= fill_q + FILLW'(cur_len_q);
			end
		end
	end

	// Parameter buffer writes.
	always_ff @(posedge clk) begin
		if (accept && is_proc && store_param) begin
			req_params_q[req_len_q[PIW-1:0]] <= param_value;
		end
	end

	// Request registers, scan counters and the pending result.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				kind_q    <= op_to_kind(opcode);
				key_a_q   <= key_a;
				key_b_q   <= ((opcode == OP_MAP) || (opcode == OP_BUF)) ? key_b : '0;
				cur_len_q <= is_proc ? len_next : '0;
				scan_q    <= '0;
				qhit_q    <= qhit;
				res_status_q <= STAT_TOO_LONG;
				res_index_q  <= '0;
				res_kind_q   <= KIND_NONE;
			end
			S_QREAD: begin
				res_status_q <= STAT_FOUND;
				res_index_q  <= '0;
				res_kind_q   <= qhit_q ? ent_rdata[KIND_LO +: KIND_W] : KIND_NONE;
			end
			S_SCAN: begin
				k_q <= '0;
			end
			S_CHECK: begin
				off_q <= ent_rdata[OFF_LO +: FILLW];
				if (!ent_match) begin
					scan_q <= scan_q + CNTW'(1);
				end
			end
			S_PREAD: begin
				param_q <= req_param_rd;
				res_status_q <= STAT_FOUND;
				res_index_q  <= first_free_q + INDEX_W'(scan_q);
				res_kind_q   <= kind_q;
			end
			S_PCMP: begin
				if (pool_rdata == param_q) begin
					k_q <= k_q + LENW'(1);
				end else begin
					scan_q <= scan_q + CNTW'(1);
				end
			end
			S_INSERT: begin
				res_status_q <= STAT_FULL;
				res_index_q  <= '0;
				res_kind_q   <= KIND_NONE;
			end
			S_COPY: begin
				if (k_q == cur_len_q) begin
					res_status_q <= STAT_ADDED;
					res_index_q  <= next_idx[INDEX_W-1:0];
					res_kind_q   <= kind_q;
				end else begin
					k_q <= k_q + LENW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_RESP) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_RESP) && out_free) begin
			out_status_q <= res_status_q;
			out_index_q  <= res_index_q;
			out_kind_q   <= res_kind_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign index     = out_index_q;
	assign kind      = out_kind_q;

endmodule

`default_nettype wire

[sim/sit_checker.sv]
`default_nettype none

module sit_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [sit_pkg::INDEX_W-1:0]    cfg_wdata,
	input  wire logic                           in_valid,
	input  wire logic                           in_stall,
	input  wire logic [sit_pkg::OPCODE_W-1:0]   opcode,
	input  wire logic [sit_pkg::KEY_W-1:0]      key_a,
	input  wire logic [sit_pkg::KEY_W-1:0]      key_b,
	input  wire logic [sit_pkg::KEY_W-1:0]      param_value,
	input  wire logic                           param_valid,
	input  wire logic                           last,
	input  wire logic                           out_valid,
	input  wire logic                           out_stall,
	input  wire logic [sit_pkg::STATUS_W-1:0]   status,
	input  wire logic [sit_pkg::INDEX_W-1:0]    index,
	input  wire logic [sit_pkg::KIND_W-1:0]     kind,
	output int                                  errors,
	output int                                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import sit_pkg::*;

	localparam int NUM_ENTRIES = DEF_ENTRIES;
	localparam int NUM_POOL    = DEF_POOL_WORDS;
	localparam int NUM_PARAMS  = DEF_MAX_PARAMS;

	typedef struct packed {
		logic [STATUS_W-1:0] st;
		logic [INDEX_W-1:0]  idx;
		logic [KIND_W-1:0]   kd;
	} shape_result_t;

	// Shadow copy of the table state.
	logic [INDEX_W-1:0] first_free;
	logic [KIND_W-1:0]  tbl_kind [NUM_ENTRIES];
	logic [KEY_W-1:0]   tbl_key_a [NUM_ENTRIES];
	logic [KEY_W-1:0]   tbl_key_b [NUM_ENTRIES];
	int                 tbl_plen [NUM_ENTRIES];
	int                 tbl_poff [NUM_ENTRIES];
	logic [KEY_W-1:0]   pool [NUM_POOL];
	logic [KEY_W-1:0]   open_params [NUM_PARAMS];
	int                 open_len;
	bit                 open_over;
	int                 used;
	int                 pool_fill;
	shape_result_t      answers_q[$];

	assign pending = answers_q.size();

	function automatic logic [KIND_W-1:0] kind_of_op(input logic [OPCODE_W-1:0] op);
		case (op)
			OP_VEC:    return KIND_VEC;
			OP_ARR:    return KIND_ARR;
			OP_MAP:    return KIND_MAP;
			OP_BUF:    return KIND_BUF;
			OP_PTR:    return KIND_PTR;
			OP_FUTURE: return KIND_FUTURE;
			OP_BOX:    return KIND_BOX;
			default:   return KIND_PROC;
		endcase
	endfunction

	// Find an equal entry, or append one if the table and pool have room, and return the result it gives.
	function automatic shape_result_t find_or_add(input logic [KIND_W-1:0] kd,
			input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
		int plen;
		int nxt;
		bit same;
		plen = (kd == KIND_PROC) ? open_len : 0;
		for (int j = 0; j < used; j++) begin
			if (tbl_kind[j] != kd || tbl_key_a[j] != a || tbl_key_b[j] != b)
				continue;
			if (kd == KIND_PROC) begin
				if (tbl_plen[j] != plen)
					continue;
				same = 1;
				for (int k = 0; k < plen; k++)
					if (tbl_poff[j] + k >= NUM_POOL || pool[tbl_poff[j] + k] != open_params[k])
						same = 0;
				if (!same)
					continue;
			end
			return '{STAT_FOUND, INDEX_W'(int'(first_free) + j), kd};
		end
		nxt = int'(first_free) + used;
		if (used >= NUM_ENTRIES || nxt >= NUM_ENTRIES || nxt >= int'(INDEX_LIMIT))
			return '{STAT_FULL, '0, KIND_NONE};
		if (pool_fill > NUM_POOL - plen)
			return '{STAT_FULL, '0, KIND_NONE};
		tbl_kind[used] = kd;
		tbl_key_a[used] = a;
		tbl_key_b[used] = b;
		tbl_plen[used] = plen;
		tbl_poff[used] = pool_fill;
		for (int k = 0; k < plen; k++)
			pool[pool_fill + k] = open_params[k];
		pool_fill += plen;
		used++;
		return '{STAT_ADDED, INDEX_W'(nxt), kd};
	endfunction

	// Work out the answer to one accepted item, if it has one.
	function automatic void predict_item();
		shape_result_t r;
		int j;
		logic [KEY_W-1:0] b;
		if (opcode == OP_QUERY) begin
			r = '{STAT_FOUND, '0, KIND_NONE};
			if (key_a >= KEY_W'(first_free)) begin
				j = int'(key_a - KEY_W'(first_free));
				if (key_a - KEY_W'(first_free) < KEY_W'(used))
					r.kd = tbl_kind[j];
			end
			answers_q.push_back(r);
		end else if (opcode == OP_PROC) begin
			if (param_valid) begin
				if (open_len < NUM_PARAMS) begin
					open_params[open_len] = param_value;
					open_len++;
				end else
					open_over = 1;
			end
			if (last) begin
				if (open_over)
					answers_q.push_back('{STAT_TOO_LONG, '0, KIND_NONE});
				else
					answers_q.push_back(find_or_add(KIND_PROC, key_a, '0));
				open_len = 0;
				open_over = 0;
			end
		end else if (opcode < OP_PROC) begin
			b = (opcode == OP_MAP || opcode == OP_BUF) ? key_b : '0;
			answers_q.push_back(find_or_add(kind_of_op(opcode), key_a, b));
		end
	endfunction

	// Track configuration, predict accepted items and compare accepted results.
	always @(posedge clk or negedge arst_n) begin
		shape_result_t want;
		if (!arst_n) begin
			first_free = FIRST_FREE_RESET;
			used = 0;
			pool_fill = 0;
			open_len = 0;
			open_over = 0;
			errors = 0;
			answers_q.delete();
		end else begin
			if (cfg_we)
				first_free = cfg_wdata;
			if (in_valid && !in_stall)
				predict_item();
			if (out_valid && !out_stall) begin
				if (answers_q.size() == 0) begin
					$error("unexpected result: status %0d index %0d kind %0d",
						status, index, kind);
					errors++;
				end else begin
					want = answers_q.pop_front();
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						errors++;
					end
					if (index !== want.idx) begin
						$error("index: expected %0d, got %0d", want.idx, index);
						errors++;
					end
					if (kind !== want.kd) begin
						$error("kind: expected %0d, got %0d", want.kd, kind);
						errors++;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

[sim/tb_shape_intern_table.sv]
`default_nettype none

module tb_shape_intern_table;
	timeunit 1ns;
	timeprecision 1ps;

	import sit_pkg::*;

	localparam int CYCLE_LIMIT = 40_000_000;
	localparam int SETTLE      = 2000;

	logic                clk = 0;
	logic                arst_n = 0;
	logic                cfg_we = 0;
	logic [INDEX_W-1:0]  cfg_wdata = '0;
	logic                in_valid = 0;
	logic                in_stall;
	logic [OPCODE_W-1:0] opcode = '0;
	logic [KEY_W-1:0]    key_a = '0;
	logic [KEY_W-1:0]    key_b = '0;
	logic [KEY_W-1:0]    param_value = '0;
	logic                param_valid = 0;
	logic                last = 1;
	logic                out_valid;
	logic                out_stall = 0;
	logic [STATUS_W-1:0] status;
	logic [INDEX_W-1:0]  index;
	logic [KIND_W-1:0]   kind;
	int                  errors;
	int                  pending;
	int                  send_idle_pct = 0;
	int                  recv_idle_pct = 0;
	int                  cycles = 0;

	shape_intern_table uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .key_a(key_a),
		.key_b(key_b), .param_value(param_value), .param_valid(param_valid), .last(last),
		.out_valid(out_valid), .out_stall(out_stall), .status(status), .index(index),
		.kind(kind)
	);

	sit_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .key_a(key_a),
		.key_b(key_b), .param_value(param_value), .param_valid(param_valid), .last(last),
		.out_valid(out_valid), .out_stall(out_stall), .status(status), .index(index),
		.kind(kind), .errors(errors), .pending(pending)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Receiver stalls at random, at the rate of the current phase.
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_idle_pct);

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_shape_intern_table: errors");
			$finish;
		end
	end

	// Present one item and hold it until the block takes it.
	task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [KEY_W-1:0] a,
			input logic [KEY_W-1:0] b, input logic [KEY_W-1:0] pv, input logic pvld,
			input logic lst);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid = 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		opcode = op;
		key_a = a;
		key_b = b;
		param_value = pv;
		param_valid = pvld;
		last = lst;
		in_valid = 1;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	// Let the block go idle: every answer back, then the longest scan time.
	task automatic drain();
		in_valid = 0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_first_free(input logic [INDEX_W-1:0] value);
		drain();
		cfg_wdata = value;
		cfg_we = 1;
		@(negedge clk);
		cfg_we = 0;
	endtask

	// Mostly a few small keys so that lookups hit, sometimes extremes or noise.
	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return KEY_W'($urandom_range(5));
		else if (r < 90)
			return '1;
		return $urandom;
	endfunction

	function automatic logic [OPCODE_W-1:0] OP_OPCODE_RAND();
		return OPCODE_W'($urandom_range(OP_BOX));
	endfunction

	// One proc request: a parameter list with random content, noise now and then.
	task automatic send_proc(input int nparams);
		logic [KEY_W-1:0] ret;
		ret = pick_key();
		for (int k = 0; k < nparams; k++) begin
			if ($urandom_range(19) == 0)
				send_item(OP_PROC, $urandom, $urandom, $urandom, 1'b0, 1'b0);
			if ($urandom_range(29) == 0)
				send_item(OP_OPCODE_RAND(), pick_key(), pick_key(), $urandom, 1'b1, 1'b1);
			send_item(OP_PROC, $urandom, $urandom, pick_key(), 1'b1, 1'b0);
		end
		send_item(OP_PROC, ret, $urandom, pick_key(), 1'($urandom_range(1)), 1'b1);
	endtask

	// One random request of any kind.
	task automatic send_random();
		int r;
		r = $urandom_range(99);
		if (r < 50)
			send_item(OP_OPCODE_RAND(), pick_key(), pick_key(), $urandom,
				1'($urandom_range(1)), 1'($urandom_range(1)));
		else if (r < 70)
			send_proc(($urandom_range(9) == 0) ? $urandom_range(15, 18) : $urandom_range(3));
		else if (r < 90)
			send_item(OP_QUERY, ($urandom_range(3) == 0) ? $urandom
				: KEY_W'($urandom_range(4095)), $urandom, $urandom,
				1'($urandom_range(1)), 1'($urandom_range(1)));
		else
			send_item(OPCODE_W'($urandom_range(OP_QUERY + 1, 15)), $urandom, $urandom,
				$urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: every shape kind, repeats, key extremes.
		send_item(OP_VEC, '0, '1, '0, 1'b0, 1'b1);
		send_item(OP_VEC, '1, '0, '1, 1'b1, 1'b0);
		send_item(OP_VEC, '0, 32'h5a5a5a5a, '0, 1'b0, 1'b1);
		send_item(OP_ARR, 32'd7, '0, '0, 1'b0, 1'b1);
		send_item(OP_MAP, 32'd3, '1, '0, 1'b0, 1'b1);
		send_item(OP_MAP, 32'd3, '1, '0, 1'b0, 1'b1);
		send_item(OP_BUF, '1, 32'd4, '0, 1'b0, 1'b1);
		send_item(OP_PTR, 32'd2, '0, '0, 1'b0, 1'b1);
		send_item(OP_FUTURE, 32'd2, '0, '0, 1'b0, 1'b1);
		send_item(OP_BOX, 32'd2, '0, '0, 1'b0, 1'b1);
		// Procs: empty list, a list, the same list again, a different list.
		send_item(OP_PROC, 32'd9, '0, '0, 1'b0, 1'b1);
		send_item(OP_PROC, '0, '0, 32'd1, 1'b1, 1'b0);
		send_item(OP_PROC, 32'd9, '0, '1, 1'b1, 1'b1);
		send_item(OP_PROC, '0, '0, 32'd1, 1'b1, 1'b0);
		send_item(OP_PROC, 32'd9, '0, '1, 1'b1, 1'b1);
		send_item(OP_PROC, '0, '0, 32'd2, 1'b1, 1'b0);
		// Another request while a proc list is open.
		send_item(OP_ARR, 32'd7, '0, '0, 1'b0, 1'b1);
		send_item(OP_PROC, 32'd9, '0, '1, 1'b1, 1'b1);
		// Queries: reserved, stored, past the end; unknown opcodes.
		send_item(OP_QUERY, 32'd0, '0, '0, 1'b0, 1'b1);
		send_item(OP_QUERY, 32'd2, '0, '0, 1'b0, 1'b1);
		send_item(OP_QUERY, '1, '0, '0, 1'b0, 1'b1);
		send_item(4'd9, '0, '0, '0, 1'b1, 1'b1);
		send_item(4'd15, '1, '1, '1, 1'b1, 1'b1);
		// A list one parameter too long.
		for (int k = 0; k < DEF_MAX_PARAMS; k++)
			send_item(OP_PROC, '0, '0, KEY_W'(k), 1'b1, 1'b0);
		send_item(OP_PROC, 32'd9, '0, '1, 1'b1, 1'b1);

		// Random phases; a high first free index keeps the table short.
		write_first_free(12'd3950);
		send_idle_pct = 22;
		recv_idle_pct = 78;
		repeat (400) send_random();
		write_first_free(12'd4095);
		send_idle_pct = 78;
		recv_idle_pct = 22;
		repeat (180) send_random();
		write_first_free(12'd3990);
		repeat (220) send_random();
		write_first_free(12'd0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (290) send_random();

		// A low first free index renumbers everything stored so far.
		write_first_free(12'd1);
		repeat (60) send_random();

		drain();
		if (errors == 0)
			$display("tb_shape_intern_table: clean");
		else
			$display("tb_shape_intern_table: errors");
		$finish;
	end

endmodule

`default_nettype wire
